// ===== src/entropy_delta_health_monitor_core_defines.svh =====
// assertion macros used by the checker file
`ifndef ENTROPY_DELTA_HEALTH_MONITOR_CORE_DEFINES_SVH
`define ENTROPY_DELTA_HEALTH_MONITOR_CORE_DEFINES_SVH

// immediate implication on the same clock edge
`define EDHM_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication on the next clock edge
`define EDHM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/edhm_pkg.sv =====
// types, codes and constants of the entropy delta health monitor
`default_nettype none

package edhm_pkg;

    localparam int unsigned DELTA_W         = 64;
    localparam int unsigned RUN_W           = 16;
    localparam int unsigned PROP_W          = 11;
    localparam int unsigned SYMBOL_BITS_DEF = 8;
    localparam int unsigned APT_WINDOW      = 512;
    localparam int unsigned PADDR_W         = 4;
    localparam int unsigned PDATA_W         = 32;

    localparam logic [PROP_W-1:0] APT_WINDOW_CNT = PROP_W'(APT_WINDOW);
    localparam logic [PROP_W-1:0] PROP_MAX       = '1;
    localparam logic [RUN_W-1:0]  RUN_MAX        = '1;

    // command codes of the func field
    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    // verdict codes
    localparam logic [1:0] V_OK   = 2'd0;
    localparam logic [1:0] V_REP  = 2'd1;
    localparam logic [1:0] V_PROP = 2'd2;
    localparam logic [1:0] V_PERM = 2'd3;

    // register indexes, byte address is four times the index
    localparam logic [1:0] REG_STUCK_CUTOFF    = 2'd0;
    localparam logic [1:0] REG_APT_CUTOFF      = 2'd1;
    localparam logic [1:0] REG_RCT_PERM_CUTOFF = 2'd2;
    localparam logic [1:0] REG_APT_PERM_CUTOFF = 2'd3;

    typedef struct packed {
        logic [RUN_W-1:0]  stuck_cutoff;
        logic [PROP_W-1:0] apt_cutoff;
        logic [RUN_W-1:0]  rct_perm_cutoff;
        logic [PROP_W-1:0] apt_perm_cutoff;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/edhm_tests.sv =====
// stuck, repetition count and adaptive proportion tests with their state
`default_nettype none

module edhm_tests
    import edhm_pkg::*;
#(
    parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_func,
    input  wire logic [DELTA_W-1:0] i_raw_delta,
    output logic      [1:0]         o_verdict,
    output logic      [DELTA_W-1:0] o_delta_out
);

    logic [DELTA_W-1:0]     r_prev_delta,      n_prev_delta;
    logic [DELTA_W-1:0]     r_prev_first_diff, n_prev_first_diff;
    logic [RUN_W-1:0]       r_stuck_run,       n_stuck_run;
    logic [SYMBOL_BITS-1:0] r_rep_symbol,      n_rep_symbol;
    logic [RUN_W-1:0]       r_rep_count,       n_rep_count;
    logic [SYMBOL_BITS-1:0] r_prop_base,       n_prop_base;
    logic                   r_prop_base_valid, n_prop_base_valid;
    logic [PROP_W-1:0]      r_prop_count,      n_prop_count;
    logic [PROP_W-1:0]      r_prop_seen,       n_prop_seen;
    logic [1:0]             r_verdict,         n_verdict;

    logic [DELTA_W-1:0]     first_diff;
    logic [DELTA_W-1:0]     second_diff;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   any_zero;
    logic                   stuck_on;
    logic [RUN_W-1:0]       s_run;
    logic                   stuck_hit;
    logic                   rct_restart;
    logic [RUN_W-1:0]       s_rep_count;
    logic                   rct_hit;
    logic                   rct_perm;
    logic [SYMBOL_BITS-1:0] s_prop_base;
    logic                   s_prop_valid;
    logic [PROP_W-1:0]      s_prop_count;
    logic [PROP_W-1:0]      s_prop_seen;
    logic                   prop_hit;
    logic                   apt_perm;
    logic [1:0]             s_verdict;

    // sample path
    always_comb begin
        sym        = i_raw_delta[SYMBOL_BITS-1:0];
        first_diff = (i_raw_delta > r_prev_delta) ? i_raw_delta - r_prev_delta
                                                  : r_prev_delta - i_raw_delta;
        second_diff = (first_diff > r_prev_first_diff) ? first_diff - r_prev_first_diff
                                                       : r_prev_first_diff - first_diff;
        any_zero = (i_raw_delta == '0) || (first_diff == '0) || (second_diff == '0);

        // stuck run never passes the cutoff
        stuck_on = (i_cfg.stuck_cutoff != '0);
        if (!any_zero) begin
            s_run = '0;
        end else if (stuck_on && (r_stuck_run < i_cfg.stuck_cutoff)) begin
            s_run = r_stuck_run + 1'b1;
        end else begin
            s_run = r_stuck_run;
        end
        stuck_hit = any_zero && stuck_on && (s_run >= i_cfg.stuck_cutoff);

        rct_restart = (r_rep_count == '0) || (sym != r_rep_symbol);
        if (rct_restart) begin
            s_rep_count = RUN_W'(1);
        end else if (r_rep_count != RUN_MAX) begin
            s_rep_count = r_rep_count + 1'b1;
        end else begin
            s_rep_count = r_rep_count;
        end
        rct_hit  = !rct_restart && (s_rep_count >= i_cfg.stuck_cutoff);
        rct_perm = (s_rep_count >= i_cfg.rct_perm_cutoff);

        // proportion window, base taken from the first sample with no valid base
        prop_hit = 1'b0;
        if (!r_prop_base_valid) begin
            s_prop_base  = sym;
            s_prop_valid = 1'b1;
            s_prop_count = PROP_W'(1);
            s_prop_seen  = PROP_W'(1);
        end else begin
            s_prop_base  = r_prop_base;
            s_prop_count = r_prop_count;
            if (sym == r_prop_base) begin
                if (r_prop_count != PROP_MAX) begin
                    s_prop_count = r_prop_count + 1'b1;
                end
                prop_hit = (s_prop_count >= i_cfg.apt_cutoff);
            end
            s_prop_seen  = (r_prop_seen != PROP_MAX) ? r_prop_seen + 1'b1 : r_prop_seen;
            s_prop_valid = (s_prop_seen < APT_WINDOW_CNT);
        end
        apt_perm = (i_cfg.apt_perm_cutoff != '0) && (s_prop_count >= i_cfg.apt_perm_cutoff);

        // first intermittent code sticks, permanent overrides
        if (r_verdict == V_PERM || rct_perm || apt_perm) begin
            s_verdict = V_PERM;
        end else if (r_verdict != V_OK) begin
            s_verdict = r_verdict;
        end else if (stuck_hit || rct_hit) begin
            s_verdict = V_REP;
        end else if (prop_hit) begin
            s_verdict = V_PROP;
        end else begin
            s_verdict = V_OK;
        end
    end

    // command decode
    always_comb begin
        n_prev_delta      = r_prev_delta;
        n_prev_first_diff = r_prev_first_diff;
        n_stuck_run       = r_stuck_run;
        n_rep_symbol      = r_rep_symbol;
        n_rep_count       = r_rep_count;
        n_prop_base       = r_prop_base;
        n_prop_base_valid = r_prop_base_valid;
        n_prop_count      = r_prop_count;
        n_prop_seen       = r_prop_seen;
        n_verdict         = r_verdict;
        if (i_accept) begin
            unique case (i_func)
                FUNC_SAMPLE: begin
                    n_stuck_run       = s_run;
                    n_rep_count       = s_rep_count;
                    n_prop_base_valid = s_prop_valid;
                    n_prop_count      = s_prop_count;
                    n_prop_seen       = s_prop_seen;
                    n_verdict         = s_verdict;
                    // a permanent failure wipes the history
                    if (s_verdict == V_PERM) begin
                        n_prev_delta      = '0;
                        n_prev_first_diff = '0;
                        n_rep_symbol      = '0;
                        n_prop_base       = '0;
                    end else begin
                        n_prev_delta      = i_raw_delta;
                        n_prev_first_diff = first_diff;
                        n_rep_symbol      = rct_restart ? sym : r_rep_symbol;
                        n_prop_base       = s_prop_base;
                    end
                end
                FUNC_RESTART: begin
                    n_prev_delta      = '0;
                    n_prev_first_diff = '0;
                    n_stuck_run       = '0;
                    n_rep_symbol      = '0;
                    n_rep_count       = '0;
                    n_prop_base       = '0;
                    n_prop_base_valid = 1'b0;
                    n_prop_count      = '0;
                    n_prop_seen       = '0;
                    n_verdict         = V_OK;
                end
                FUNC_CLEAR: begin
                    if (r_verdict == V_REP || r_verdict == V_PROP) begin
                        n_verdict = V_OK;
                    end
                end
                FUNC_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_delta      <= '0;
            r_prev_first_diff <= '0;
            r_stuck_run       <= '0;
            r_rep_symbol      <= '0;
            r_rep_count       <= '0;
            r_prop_base       <= '0;
            r_prop_base_valid <= 1'b0;
            r_prop_count      <= '0;
            r_prop_seen       <= '0;
            r_verdict         <= V_OK;
        end else begin
            r_prev_delta      <= n_prev_delta;
            r_prev_first_diff <= n_prev_first_diff;
            r_stuck_run       <= n_stuck_run;
            r_rep_symbol      <= n_rep_symbol;
            r_rep_count       <= n_rep_count;
            r_prop_base       <= n_prop_base;
            r_prop_base_valid <= n_prop_base_valid;
            r_prop_count      <= n_prop_count;
            r_prop_seen       <= n_prop_seen;
            r_verdict         <= n_verdict;
        end
    end

    assign o_verdict   = r_verdict;
    assign o_delta_out = r_prev_delta;

endmodule

`default_nettype wire

// ===== src/entropy_delta_health_monitor_core.sv =====
// top level of the entropy delta health monitor
//
//  channel   direction  handshake                  payload
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//  sample    in         i_in_valid/o_in_ready      i_func, i_raw_delta
//  result    out        o_out_valid/i_out_ready    o_verdict, o_delta_out
//
// one item per cycle unless the sink stalls a held result: the item is decoded and the test
// state updated in the cycle of its transfer, the state registers then show the result
// result appears in the cycle after the input transfer
// a held result stalls input only while the sink stalls it (ready passes through)
// synchronous active-low reset clears all test state and the cutoff registers
`default_nettype none

module entropy_delta_health_monitor_core
    import edhm_pkg::*;
#(
    parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_func,
    input  wire logic [DELTA_W-1:0] i_raw_delta,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [1:0]         o_verdict,
    output logic      [DELTA_W-1:0] o_delta_out
);

    t_cfg       r_cfg, n_cfg;
    logic       r_out_valid, n_out_valid;
    logic       cfg_write;
    logic [1:0] reg_index;
    logic       accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_write) begin
            unique case (reg_index)
                REG_STUCK_CUTOFF:    n_cfg.stuck_cutoff    = pwdata[RUN_W-1:0];
                REG_APT_CUTOFF:      n_cfg.apt_cutoff      = pwdata[PROP_W-1:0];
                REG_RCT_PERM_CUTOFF: n_cfg.rct_perm_cutoff = pwdata[RUN_W-1:0];
                REG_APT_PERM_CUTOFF: n_cfg.apt_perm_cutoff = pwdata[PROP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_STUCK_CUTOFF:    prdata = PDATA_W'(r_cfg.stuck_cutoff);
            REG_APT_CUTOFF:      prdata = PDATA_W'(r_cfg.apt_cutoff);
            REG_RCT_PERM_CUTOFF: prdata = PDATA_W'(r_cfg.rct_perm_cutoff);
            REG_APT_PERM_CUTOFF: prdata = PDATA_W'(r_cfg.apt_perm_cutoff);
            default:             prdata = '0;
        endcase
    end

    // state only moves on a transfer, so a held result stays put
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    edhm_tests #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_tests (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_raw_delta (i_raw_delta),
        .o_verdict   (o_verdict),
        .o_delta_out (o_delta_out)
    );

endmodule

`default_nettype wire

// ===== src/edhm_checker.sv =====
// port-level checks of the health monitor, bound to the top level
`default_nettype none

`include "entropy_delta_health_monitor_core_defines.svh"

module edhm_checker
    import edhm_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [1:0]         i_func,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [1:0]         o_verdict,
    input wire logic [DELTA_W-1:0] o_delta_out
);

    logic restart_xfer;
    logic result_stall;

    assign restart_xfer = i_in_valid && o_in_ready && (i_func == FUNC_RESTART);
    assign result_stall = o_out_valid && !i_out_ready;

    // stalled result keeps its payload
    `EDHM_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, result_stall,
        o_out_valid && $stable(o_verdict) && $stable(o_delta_out), "stalled result changed")

    // an empty result stage always takes input
    `EDHM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready,
        "input blocked with empty result stage")

    // permanent failure leaves the history zeroed
    `EDHM_ASSERT_NOW(a_perm_zero_delta, i_clk, i_rst_n, o_verdict == V_PERM, o_delta_out == '0,
        "delta kept after permanent failure")

    // only a restart lifts a permanent verdict
    `EDHM_ASSERT_NEXT(a_perm_sticky, i_clk, i_rst_n, (o_verdict == V_PERM) && !restart_xfer,
        o_verdict == V_PERM, "permanent verdict dropped")

endmodule

bind entropy_delta_health_monitor_core edhm_checker u_edhm_checker (.*);

`default_nettype wire
